// ===== rtl/bses_pkg.sv =====
// shared types and constants for the barrel switch effort sequencer
// no dependencies; used by the top level and its checker

package bses_pkg;

  // input item kinds
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_REQUEST  = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;

  // result item kinds
  localparam logic KIND_EFFORT   = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // targets
  localparam logic [1:0] TARGET_HOME = 2'd0;
  localparam logic [1:0] TARGET_AWAY = 2'd1;

  // configuration register indexes
  localparam logic [2:0] REG_EFFORT_HIGH    = 3'd0;
  localparam logic [2:0] REG_EFFORT_LOW     = 3'd1;
  localparam logic [2:0] REG_EFFORT_STEP    = 3'd2;
  localparam logic [2:0] REG_DELAY_TICKS    = 3'd3;
  localparam logic [2:0] REG_RAMP_TICKS     = 3'd4;
  localparam logic [2:0] REG_THRESHOLD_HOME = 3'd5;
  localparam logic [2:0] REG_THRESHOLD_AWAY = 3'd6;

  // reset values
  localparam logic [14:0]        EFFORT_HIGH_RST    = 15'd11050;
  localparam logic [14:0]        EFFORT_LOW_RST     = 15'd6586;
  localparam logic [14:0]        EFFORT_STEP_RST    = 15'd128;
  localparam logic [15:0]        DELAY_TICKS_RST    = 16'd30;
  localparam logic [15:0]        RAMP_TICKS_RST     = 16'd35;
  localparam logic signed [31:0] THRESHOLD_HOME_RST = -32'sd26214;
  localparam logic signed [31:0] THRESHOLD_AWAY_RST = -32'sd183501;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         target;
    logic signed [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] effort;
    logic               success;
  } out_item_t;

endpackage

// ===== rtl/barrel_switch_effort_sequencer.sv =====
// top level of the barrel switch effort sequencer: state, config registers
// and result register; depends on bses_pkg

// One item is accepted per clock cycle. A tick or a request updates the
// sequencer state at the accepting edge and loads its result into the output
// register, which presents it from the next cycle on. in_ready drops only
// while the output register holds a result that is not being taken, so the
// sustained rate is one item per cycle whenever the consumer keeps out_ready
// high. Position updates and pre-delay ticks give no result. The
// configuration port is always ready and should be written only while the
// block is idle.

module barrel_switch_effort_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bses_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bses_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [1:0] {
    PH_PRE  = 2'd0,
    PH_RAMP = 2'd1,
    PH_POST = 2'd2
  } phase_t;

  // configuration
  logic [14:0]        effort_high;
  logic [14:0]        effort_step;
  logic [15:0]        delay_ticks;
  logic [15:0]        ramp_ticks;
  logic signed [31:0] threshold_home;
  logic signed [31:0] threshold_away;

  // sequencer state
  phase_t             phase, phase_next;
  logic [15:0]        delay_elapsed, delay_elapsed_next;
  logic [15:0]        ramp_elapsed, ramp_elapsed_next;
  logic               at_away, at_away_next;
  logic               busy, busy_next;
  logic [14:0]        present_effort, present_effort_next;
  logic signed [31:0] last_position, last_position_next;

  logic                accept;
  logic                result_valid;
  bses_pkg::out_item_t result;
  logic [15:0]         delay_inc;
  logic [15:0]         ramp_inc;
  logic                pos_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign delay_inc = delay_elapsed + 16'd1;
  assign ramp_inc  = ramp_elapsed + 16'd1;

  always_comb begin
    phase_next          = phase;
    delay_elapsed_next  = delay_elapsed;
    ramp_elapsed_next   = ramp_elapsed;
    at_away_next        = at_away;
    busy_next           = busy;
    present_effort_next = present_effort;
    last_position_next  = last_position;
    result_valid        = 1'b0;
    result.kind         = bses_pkg::KIND_EFFORT;
    result.effort       = 16'sd0;
    result.success      = 1'b0;
    pos_ok              = 1'b0;

    if (in_data.mode == bses_pkg::MODE_TICK) begin
      result_valid = 1'b1;
      if (busy) begin
        unique case (phase)
          PH_PRE: begin
            // silent phase
            result_valid       = 1'b0;
            delay_elapsed_next = delay_inc;
            if (delay_inc >= delay_ticks) begin
              phase_next         = PH_RAMP;
              delay_elapsed_next = 16'd0;
            end
          end
          PH_RAMP: begin
            // saturate at zero
            if (present_effort > effort_step) begin
              present_effort_next = present_effort - effort_step;
            end else begin
              present_effort_next = 15'd0;
            end
            ramp_elapsed_next = ramp_inc;
            if (ramp_inc >= ramp_ticks) begin
              phase_next        = PH_POST;
              ramp_elapsed_next = 16'd0;
            end
          end
          PH_POST: begin
            delay_elapsed_next = delay_inc;
            if (delay_inc >= delay_ticks) begin
              phase_next         = PH_PRE;
              delay_elapsed_next = 16'd0;
              busy_next          = 1'b0;
            end
          end
          default: begin
            phase_next = PH_PRE;
          end
        endcase
      end
      if (at_away) begin
        result.effort = -$signed({1'b0, present_effort_next});
      end else begin
        result.effort = $signed({1'b0, present_effort_next});
      end
    end else if (in_data.mode == bses_pkg::MODE_REQUEST) begin
      result_valid = 1'b1;
      result.kind  = bses_pkg::KIND_RESPONSE;
      if (in_data.target == bses_pkg::TARGET_HOME) begin
        if (at_away) begin
          present_effort_next = effort_high;
          busy_next           = 1'b1;
        end
        at_away_next = 1'b0;
      end else if (in_data.target == bses_pkg::TARGET_AWAY) begin
        if (!at_away) begin
          present_effort_next = effort_high;
          busy_next           = 1'b1;
        end
        at_away_next = 1'b1;
      end
      if (at_away_next) begin
        pos_ok = last_position <= threshold_away;
      end else begin
        pos_ok = last_position >= threshold_home;
      end
      result.success = !busy_next && pos_ok;
    end else if (in_data.mode == bses_pkg::MODE_POSITION) begin
      last_position_next = in_data.position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effort_high    <= bses_pkg::EFFORT_HIGH_RST;
      effort_step    <= bses_pkg::EFFORT_STEP_RST;
      delay_ticks    <= bses_pkg::DELAY_TICKS_RST;
      ramp_ticks     <= bses_pkg::RAMP_TICKS_RST;
      threshold_home <= bses_pkg::THRESHOLD_HOME_RST;
      threshold_away <= bses_pkg::THRESHOLD_AWAY_RST;
    end else if (cfg_valid) begin
      // effort_low only sets the reset effort, so a write to it is dropped
      unique case (cfg_index)
        bses_pkg::REG_EFFORT_HIGH:    effort_high    <= cfg_data[14:0];
        bses_pkg::REG_EFFORT_STEP:    effort_step    <= cfg_data[14:0];
        bses_pkg::REG_DELAY_TICKS:    delay_ticks    <= cfg_data[15:0];
        bses_pkg::REG_RAMP_TICKS:     ramp_ticks     <= cfg_data[15:0];
        bses_pkg::REG_THRESHOLD_HOME: threshold_home <= $signed(cfg_data);
        bses_pkg::REG_THRESHOLD_AWAY: threshold_away <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_PRE;
      delay_elapsed  <= 16'd0;
      ramp_elapsed   <= 16'd0;
      at_away        <= 1'b0;
      busy           <= 1'b0;
      present_effort <= bses_pkg::EFFORT_LOW_RST;
      last_position  <= 32'sd0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        delay_elapsed  <= delay_elapsed_next;
        ramp_elapsed   <= ramp_elapsed_next;
        at_away        <= at_away_next;
        busy           <= busy_next;
        present_effort <= present_effort_next;
        last_position  <= last_position_next;
      end
      if (accept) begin
        out_valid <= result_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result_valid) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/bses_checker.sv =====
// port-level checker for the barrel switch effort sequencer, bound to the
// top level; depends on bses_pkg

module bses_sva_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bses_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bses_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input stalls only behind a full, stalled output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  // every request gets a response next cycle
  a_response: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == bses_pkg::MODE_REQUEST |=>
      out_valid && out_data.kind == bses_pkg::KIND_RESPONSE && out_data.effort == 16'sd0)
    else $error("request without response");

  // position updates give no result
  a_position: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == bses_pkg::MODE_POSITION |=> !out_valid)
    else $error("result from position update");

  // effort commands never flag success
  a_effort_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == bses_pkg::KIND_EFFORT |-> !out_data.success)
    else $error("success set on effort command");

endmodule

bind barrel_switch_effort_sequencer bses_sva_checker u_bses_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/bses_checker.sv =====
// checker for the barrel switch effort sequencer: tracks config writes and
// requests, predicts each result and compares it; depends on bses_pkg

module bses_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bses_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bses_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bses_pkg::*;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_RAMP = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  // shadow registers
  logic [14:0]        eff_high;
  logic [14:0]        eff_step;
  logic [15:0]        delay_len;
  logic [15:0]        ramp_len;
  logic signed [31:0] home_th;
  logic signed [31:0] away_th;

  // sequencer state
  logic [1:0]         seq_phase;
  logic [15:0]        delay_cnt;
  logic [15:0]        ramp_cnt;
  logic               aim_away;
  logic               running;
  logic [14:0]        cur_effort;
  logic signed [31:0] last_pos;

  out_item_t pending_results[$];
  int        result_num;

  initial begin
    errors      = 0;
    outstanding = 0;
    result_num  = 0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic clear_state();
    eff_high   = EFFORT_HIGH_RST;
    eff_step   = EFFORT_STEP_RST;
    delay_len  = DELAY_TICKS_RST;
    ramp_len   = RAMP_TICKS_RST;
    home_th    = THRESHOLD_HOME_RST;
    away_th    = THRESHOLD_AWAY_RST;
    seq_phase  = PH_PRE;
    delay_cnt  = '0;
    ramp_cnt   = '0;
    aim_away   = 1'b0;
    running    = 1'b0;
    cur_effort = EFFORT_LOW_RST;
    last_pos   = '0;
  endtask

  task automatic write_shadow(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_EFFORT_HIGH:    eff_high  = val[14:0];
      // effort_low only fixes the reset effort
      REG_EFFORT_LOW:     ;
      REG_EFFORT_STEP:    eff_step  = val[14:0];
      REG_DELAY_TICKS:    delay_len = val[15:0];
      REG_RAMP_TICKS:     ramp_len  = val[15:0];
      REG_THRESHOLD_HOME: home_th   = $signed(val);
      REG_THRESHOLD_AWAY: away_th   = $signed(val);
      default: ;
    endcase
  endtask

  // advance the sequencer by one input item; sets made when a result is due
  task automatic sequence_step(input in_item_t req, output bit made, output out_item_t res);
    logic signed [15:0] mag;
    logic               reached;
    bit                 silent;
    made   = 1'b0;
    res    = '0;
    silent = 1'b0;
    case (req.mode)
      MODE_TICK: begin
        if (running) begin
          case (seq_phase)
            PH_PRE: begin
              delay_cnt = delay_cnt + 16'd1;
              if (delay_cnt >= delay_len) begin
                seq_phase = PH_RAMP;
                delay_cnt = '0;
              end
              silent = 1'b1;
            end
            PH_RAMP: begin
              if (cur_effort > eff_step) cur_effort = cur_effort - eff_step;
              else cur_effort = '0;
              ramp_cnt = ramp_cnt + 16'd1;
              if (ramp_cnt >= ramp_len) begin
                seq_phase = PH_POST;
                ramp_cnt  = '0;
              end
            end
            PH_POST: begin
              delay_cnt = delay_cnt + 16'd1;
              if (delay_cnt >= delay_len) begin
                seq_phase = PH_PRE;
                delay_cnt = '0;
                running   = 1'b0;
              end
            end
            default: seq_phase = PH_PRE;
          endcase
        end
        if (!silent) begin
          mag        = {1'b0, cur_effort};
          made       = 1'b1;
          res.kind   = KIND_EFFORT;
          res.effort = aim_away ? -mag : mag;
        end
      end
      MODE_REQUEST: begin
        if (req.target == TARGET_HOME) begin
          if (aim_away) begin
            cur_effort = eff_high;
            running    = 1'b1;
          end
          aim_away = 1'b0;
        end else if (req.target == TARGET_AWAY) begin
          if (!aim_away) begin
            cur_effort = eff_high;
            running    = 1'b1;
          end
          aim_away = 1'b1;
        end
        reached     = aim_away ? (last_pos <= away_th) : (last_pos >= home_th);
        made        = 1'b1;
        res.kind    = KIND_RESPONSE;
        res.success = !running && reached;
      end
      MODE_POSITION: last_pos = req.position;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    bit        made;
    if (rst) begin
      clear_state();
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", result_num));
        end else begin
          want = pending_results.pop_front();
          if (out_data.kind !== want.kind)
            report($sformatf("result %0d kind %b, expected %b",
                             result_num, out_data.kind, want.kind));
          if (out_data.effort !== want.effort)
            report($sformatf("result %0d effort %0d, expected %0d",
                             result_num, out_data.effort, want.effort));
          if (out_data.success !== want.success)
            report($sformatf("result %0d success %b, expected %b",
                             result_num, out_data.success, want.success));
        end
        result_num++;
      end
      if (cfg_valid && cfg_ready) write_shadow(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sequence_step(in_data, made, fresh);
        if (made) pending_results.push_back(fresh);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== test/barrel_switch_effort_sequencer_tb.sv =====
// testbench top for the barrel switch effort sequencer: drives requests and
// config writes, varies backpressure; depends on bses_pkg and bses_checker

module barrel_switch_effort_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bses_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] TARGET_SPARE = 2'd2;
  localparam logic [1:0] TARGET_LAST  = 2'd3;
  localparam int         ITEM_GOAL    = 850;
  localparam int         CYCLE_LIMIT  = 500000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int outstanding;
  int cycle_cnt  = 0;
  int stall_left = 0;
  int item_count = 0;
  int seq_span   = 100;
  int phase_num;
  bit calm       = 1'b0;

  // thresholds last written, used to aim positions near them
  logic signed [31:0] home_th_now = THRESHOLD_HOME_RST;
  logic signed [31:0] away_th_now = THRESHOLD_AWAY_RST;

  barrel_switch_effort_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bses_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side backpressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] draw_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return home_th_now + $urandom_range(0, 8) - 4;
    if (r < 50) return away_th_now + $urandom_range(0, 8) - 4;
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] draw_threshold();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      default: return $urandom_range(0, 400000) - 200000;
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [1:0] m, input logic [1:0] t,
                                         input logic signed [31:0] p);
    in_item_t it;
    it.mode     = m;
    it.target   = t;
    it.position = p;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(input in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (it.mode != MODE_UNUSED) item_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop requests and wait until every result is in and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_all(input logic [14:0] hi, input logic [14:0] lo,
                           input logic [14:0] stp, input logic [15:0] dly,
                           input logic [15:0] rmp, input logic signed [31:0] th0,
                           input logic signed [31:0] th1);
    int span;
    write_reg(REG_EFFORT_HIGH, {17'd0, hi});
    write_reg(REG_EFFORT_LOW, {17'd0, lo});
    write_reg(REG_EFFORT_STEP, {17'd0, stp});
    write_reg(REG_DELAY_TICKS, {16'd0, dly});
    write_reg(REG_RAMP_TICKS, {16'd0, rmp});
    write_reg(REG_THRESHOLD_HOME, th0);
    write_reg(REG_THRESHOLD_AWAY, th1);
    home_th_now = th0;
    away_th_now = th1;
    span = 2 * int'(dly) + int'(rmp) + 6;
    seq_span = (span > 120) ? 120 : span;
  endtask

  task automatic configure(input int profile);
    logic [14:0]        hi;
    logic [14:0]        lo;
    logic [14:0]        stp;
    logic [15:0]        dly;
    logic [15:0]        rmp;
    logic signed [31:0] th0;
    logic signed [31:0] th1;
    hi  = 15'($urandom_range(0, 32767));
    lo  = 15'($urandom_range(0, 32767));
    stp = 15'($urandom_range(0, 2000));
    dly = 16'($urandom_range(1, 5));
    rmp = 16'($urandom_range(1, 8));
    th0 = draw_threshold();
    th1 = draw_threshold();
    case (profile)
      0: begin
        hi  = EFFORT_HIGH_RST;
        lo  = EFFORT_LOW_RST;
        stp = EFFORT_STEP_RST;
        dly = DELAY_TICKS_RST;
        rmp = RAMP_TICKS_RST;
        th0 = THRESHOLD_HOME_RST;
        th1 = THRESHOLD_AWAY_RST;
      end
      1: begin
        dly = 16'($urandom_range(1, 3));
        rmp = 16'($urandom_range(1, 4));
      end
      2: begin
        // zero lengths behave as one tick
        dly = 16'd0;
        rmp = 16'd0;
      end
      3: begin
        hi  = $urandom_range(0, 1) ? 15'h7FFF : 15'($urandom_range(0, 200));
        stp = $urandom_range(0, 1) ? 15'h7FFF : 15'd0;
      end
      4: begin
        dly = 16'hFFFF;
        rmp = 16'hFFFF;
      end
      default: stp = 15'($urandom_range(0, 32767));
    endcase
    write_all(hi, lo, stp, dly, rmp, th0, th1);
  endtask

  // mostly switch sequences: a request for the other side, then ticks mixed
  // with position updates, stray requests and ignored items
  task automatic run_phase(input int quota);
    int         stop_at;
    int         ticks;
    int         r;
    logic [1:0] aim;
    stop_at = item_count + quota;
    aim     = TARGET_AWAY;
    while (item_count < stop_at) begin
      push_item(make_item(MODE_REQUEST, aim, draw_position()));
      ticks = $urandom_range(0, seq_span);
      repeat (ticks) begin
        r = $urandom_range(0, 99);
        if (r < 75)
          push_item(make_item(MODE_TICK, 2'($urandom_range(0, 3)), draw_position()));
        else if (r < 88)
          push_item(make_item(MODE_POSITION, 2'($urandom_range(0, 3)), draw_position()));
        else if (r < 96)
          push_item(make_item(MODE_REQUEST, 2'($urandom_range(0, 3)), draw_position()));
        else
          push_item(make_item(MODE_UNUSED, 2'($urandom_range(0, 3)), $urandom));
      end
      if ($urandom_range(0, 3) != 0) aim = (aim == TARGET_HOME) ? TARGET_AWAY : TARGET_HOME;
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: idle tick, responses at position extremes, bad targets,
    // a start, pre-delay ticks, and requests while switching
    push_item(make_item(MODE_TICK, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_POSITION, TARGET_HOME, 32'sh7FFF_FFFF));
    push_item(make_item(MODE_REQUEST, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_POSITION, TARGET_LAST, 32'sh8000_0000));
    push_item(make_item(MODE_REQUEST, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_SPARE, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_LAST, 32'sd0));
    push_item(make_item(MODE_UNUSED, TARGET_AWAY, -32'sd1));
    push_item(make_item(MODE_REQUEST, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_SPARE, -32'sd1));
    push_item(make_item(MODE_TICK, TARGET_LAST, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_HOME, 32'sd0));
    settle();

    // extreme settings: saturating ramp, zero lengths, widest thresholds
    write_all(15'h7FFF, 15'd0, 15'h7FFF, 16'd0, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_item(make_item(MODE_TICK, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_HOME, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_TICK, TARGET_AWAY, 32'sd0));
    push_item(make_item(MODE_REQUEST, TARGET_AWAY, 32'sh7FFF_FFFF));
    settle();

    item_count = 0;
    phase_num  = 0;
    while (item_count < ITEM_GOAL) begin
      configure(phase_num % 6);
      calm = ($urandom_range(0, 3) == 0);
      run_phase((phase_num % 6 == 4) ? 60 : 110);
      settle();
      phase_num++;
    end

    calm = 1'b0;
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
